### src/assert_macros.svh
// Assertion macros for the RTL of the telemetry decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on the rising clock, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds on the rising clock, off while reset is low.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/tdd_pkg.sv
// Shared types, widths and constants of the direct-format telemetry decoder.
`timescale 1ns / 1ps

package tdd_pkg;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int RAW_W  = 16;
    localparam int VAL_W  = 38;
    localparam int RES_W  = 20;
    localparam int VIN_W  = 21;
    localparam int IIN_W  = 34;

    // Arithmetic widths
    localparam int K_W    = 40;   // largest scale factor 10^12
    localparam int NUM_W  = 57;   // signed Y*K + offset
    localparam int DVD_W  = 55;   // rounded dividend magnitude
    localparam int DEN_W  = 34;   // 9538 * (2^20 - 1)
    localparam int CNT_W  = 6;    // holds DVD_W
    localparam int E_W    = 55;   // V * I in microwatts
    localparam int P_W    = 48;   // reported power in microwatts
    localparam int CMP_W  = 60;

    // Channel codes
    localparam logic [FUNC_W-1:0] FUNC_VIN  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_VOUT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_IIN  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PIN  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TEMP = 3'd4;

    // Scale factors on Y
    localparam logic [K_W-1:0] K_VOLT = 40'd100000;
    localparam logic [K_W-1:0] K_CURR = 40'd100000000000;
    localparam logic [K_W-1:0] K_POW  = 40'd1000000000000;
    localparam logic [K_W-1:0] K_TEMP = 40'd5000;
    localparam logic signed [NUM_W-1:0] B_TEMP = -57'sd1605000;

    // Divisors and resistor gains
    localparam logic [DEN_W-1:0] DEN_VOLT = 34'd5251;
    localparam logic [DEN_W-1:0] DEN_TEMP = 34'd7;
    localparam logic [DEN_W-1:0] DEN_ONE  = 34'd1;
    localparam logic [DEN_W-1:0] G_CURR   = 34'd9538;
    localparam logic [DEN_W-1:0] G_POW    = 34'd4901;

    localparam logic [RES_W-1:0] RES_RESET = 20'd100000;
    localparam logic [RES_W-1:0] RES_ONE   = 20'd1;

    localparam logic signed [E_W-1:0] E_MIN   = 55'sd100000;
    localparam logic signed [P_W-1:0] P_SCALE = 48'sd1000;

    // Status of the bit-serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/tdd_bitdiv.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tdd_bitdiv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tdd_pkg::DVD_W-1:0]      i_dividend,
    input  logic [tdd_pkg::DEN_W-1:0]      i_divisor,
    output logic [tdd_pkg::DVD_W-1:0]      o_quotient,
    output tdd_pkg::t_div_stat             o_stat
);

    logic [tdd_pkg::DVD_W-1:0] r_dvd, n_dvd;   // dividend bits out, quotient bits in
    logic [tdd_pkg::DEN_W-1:0] r_rem, n_rem;
    logic [tdd_pkg::DEN_W-1:0] r_den;
    logic [tdd_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [tdd_pkg::DEN_W:0]   w_trial;
    logic                      w_fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_dvd[tdd_pkg::DVD_W-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
        n_rem   = w_fits ? tdd_pkg::DEN_W'(w_trial - {1'b0, r_den})
                         : tdd_pkg::DEN_W'(w_trial);
        n_dvd   = {r_dvd[tdd_pkg::DVD_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= tdd_pkg::CNT_W'(tdd_pkg::DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tdd_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_dvd;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### src/telemetry_direct_decode.sv
// Top level: direct-format telemetry decoder with power cross-check.
// One item at a time passes through the engine and its 55-step bit-serial divider.
// The result register frees the engine: a new item is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears the handshake and engine state,
// sets the monitor resistor to 100000 centiohm and zeroes the stored V and I.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module telemetry_direct_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: monitor resistor in hundredths of an ohm
    input  logic                          i_cfg_we,
    input  logic [tdd_pkg::RES_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,   // [15:0] raw_word
    input  logic [2:0]                    i_s_tuser,   // [2:0] func
    // Result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [39:0]                   o_m_tdata,   // [37:0] value_milli, [38] pwr_alarm
    output logic [2:0]                    o_m_tuser    // [2:0] channel
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_ADD   = 9'b000000100,
        S_START = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_SAT   = 9'b000100000,
        S_PMUL  = 9'b001000000,
        S_DIFF  = 9'b010000000,
        S_CMP   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration and stored telemetry
    logic        [tdd_pkg::RES_W-1:0] r_imon;
    logic signed [tdd_pkg::VIN_W-1:0] r_vin;
    logic signed [tdd_pkg::IIN_W-1:0] r_iin;

    // Item payload and pipeline registers
    logic        [tdd_pkg::FUNC_W-1:0] r_func;
    logic signed [tdd_pkg::RAW_W-1:0]  r_raw;
    logic signed [tdd_pkg::NUM_W-1:0]  r_prod;
    logic signed [tdd_pkg::NUM_W-1:0]  r_num;
    logic        [tdd_pkg::DEN_W-1:0]  r_den;
    logic signed [tdd_pkg::E_W-1:0]    r_e;
    logic                              r_neg;
    logic signed [tdd_pkg::VAL_W-1:0]  r_val;
    logic signed [tdd_pkg::P_W-1:0]    r_p;
    logic        [tdd_pkg::DVD_W-1:0]  r_diff;
    logic                              r_e_big;

    // Output register
    logic                              r_m_valid;
    logic        [tdd_pkg::FUNC_W-1:0] r_m_chan;
    logic signed [tdd_pkg::VAL_W-1:0]  r_m_val;
    logic                              r_m_mism;

    // Combinational helpers
    logic        [tdd_pkg::K_W-1:0]    w_k;
    logic        [tdd_pkg::RES_W-1:0]  w_c;
    logic        [tdd_pkg::DEN_W-1:0]  w_den;
    logic signed [tdd_pkg::NUM_W-1:0]  w_bias;
    logic signed [tdd_pkg::NUM_W-1:0]  w_half;
    logic signed [tdd_pkg::NUM_W-1:0]  w_dvd_full;
    logic        [tdd_pkg::DVD_W-1:0]  w_quot;
    logic                              w_ovf;
    logic signed [tdd_pkg::VAL_W-1:0]  w_val;
    logic signed [tdd_pkg::E_W:0]      w_e_ext;
    logic signed [tdd_pkg::E_W:0]      w_p_ext;
    logic        [tdd_pkg::CMP_W-1:0]  w_lhs;
    logic        [tdd_pkg::CMP_W-1:0]  w_rhs;
    logic                              w_mism;
    logic signed [tdd_pkg::IIN_W-1:0]  w_iin_sat;
    logic                              w_in_xfer;
    logic                              w_out_free;
    logic                              w_div_start;
    logic                              w_flag_other;
    tdd_pkg::t_div_stat                w_div_stat;

    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_div_start = (r_state == S_START);

    // Scale factor, offset and divisor for the channel
    always_comb begin
        w_c = (r_imon == '0) ? tdd_pkg::RES_ONE : r_imon;
        case (r_func)
            tdd_pkg::FUNC_VIN,
            tdd_pkg::FUNC_VOUT: begin
                w_k    = tdd_pkg::K_VOLT;
                w_bias = '0;
                w_den  = tdd_pkg::DEN_VOLT;
            end
            tdd_pkg::FUNC_IIN: begin
                w_k    = tdd_pkg::K_CURR;
                w_bias = '0;
                w_den  = tdd_pkg::DEN_W'(tdd_pkg::G_CURR * tdd_pkg::DEN_W'(w_c));
            end
            tdd_pkg::FUNC_PIN: begin
                w_k    = tdd_pkg::K_POW;
                w_bias = '0;
                w_den  = tdd_pkg::DEN_W'(tdd_pkg::G_POW * tdd_pkg::DEN_W'(w_c));
            end
            tdd_pkg::FUNC_TEMP: begin
                w_k    = tdd_pkg::K_TEMP;
                w_bias = tdd_pkg::B_TEMP;
                w_den  = tdd_pkg::DEN_TEMP;
            end
            default: begin
                // Unused selector: zero numerator gives a zero result.
                w_k    = '0;
                w_bias = '0;
                w_den  = tdd_pkg::DEN_ONE;
            end
        endcase
    end

    // Fold the half-divisor into the magnitude so the divider rounds to nearest.
    always_comb begin
        w_half     = tdd_pkg::NUM_W'(r_den >> 1);
        w_dvd_full = r_num[tdd_pkg::NUM_W-1] ? (w_half - r_num) : (r_num + w_half);
    end

    // Sign the quotient and clamp it to the value field.
    always_comb begin
        w_ovf = |w_quot[tdd_pkg::DVD_W-1:tdd_pkg::VAL_W-1];
        if (r_neg) begin
            w_val = w_ovf ? {1'b1, {(tdd_pkg::VAL_W-1){1'b0}}}
                          : -tdd_pkg::VAL_W'(w_quot[tdd_pkg::VAL_W-2:0]);
        end else begin
            w_val = w_ovf ? {1'b0, {(tdd_pkg::VAL_W-1){1'b1}}}
                          : tdd_pkg::VAL_W'(w_quot[tdd_pkg::VAL_W-2:0]);
        end
    end

    // Power cross-check on input power with E above E_MIN: 20*|E - P| > 3*E, written as shifts and adds.
    always_comb begin
        w_e_ext = (tdd_pkg::E_W+1)'(r_e);
        w_p_ext = (tdd_pkg::E_W+1)'(r_p);
        w_lhs   = (tdd_pkg::CMP_W'(r_diff) << 4) + (tdd_pkg::CMP_W'(r_diff) << 2);
        w_rhs   = (tdd_pkg::CMP_W'(r_e[tdd_pkg::E_W-2:0]) << 1)
                + tdd_pkg::CMP_W'(r_e[tdd_pkg::E_W-2:0]);
        w_mism  = (r_func == tdd_pkg::FUNC_PIN) && r_e_big && (w_lhs > w_rhs);
    end

    // Clamp the decoded current to the stored width.
    always_comb begin
        if (r_val[tdd_pkg::VAL_W-1:tdd_pkg::IIN_W-1] == '0 ||
            r_val[tdd_pkg::VAL_W-1:tdd_pkg::IIN_W-1] == '1) begin
            w_iin_sat = r_val[tdd_pkg::IIN_W-1:0];
        end else if (r_val[tdd_pkg::VAL_W-1]) begin
            w_iin_sat = {1'b1, {(tdd_pkg::IIN_W-1){1'b0}}};
        end else begin
            w_iin_sat = {1'b0, {(tdd_pkg::IIN_W-1){1'b1}}};
        end
    end

    // Sequencer: one item at a time; hold the last step until the result register frees.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (w_div_stat.done) n_state = S_SAT;
            S_SAT:   n_state = S_PMUL;
            S_PMUL:  n_state = S_DIFF;
            S_DIFF:  n_state = S_CMP;
            S_CMP:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and stored telemetry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_imon    <= tdd_pkg::RES_RESET;
            r_vin     <= '0;
            r_iin     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_imon <= i_cfg_wdata;
            end
            if (r_state == S_CMP && w_out_free) begin
                r_m_valid <= 1'b1;
                // Only input voltage and input current update the stored values.
                if (r_func == tdd_pkg::FUNC_VIN) begin
                    r_vin <= r_val[tdd_pkg::VIN_W-1:0];
                end
                if (r_func == tdd_pkg::FUNC_IIN) begin
                    r_iin <= w_iin_sat;
                end
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= i_s_tuser;
            r_raw  <= i_s_tdata;
        end
        if (r_state == S_MUL) begin
            // Three independent values, each registered: scaled word, divisor and V*I.
            r_prod <= tdd_pkg::NUM_W'(r_raw) * tdd_pkg::NUM_W'($signed({1'b0, w_k}));
            r_den  <= w_den;
            r_e    <= tdd_pkg::E_W'(r_vin) * tdd_pkg::E_W'(r_iin);
        end
        if (r_state == S_ADD) begin
            r_num <= r_prod + w_bias;
        end
        if (r_state == S_START) begin
            r_neg <= r_num[tdd_pkg::NUM_W-1];
        end
        if (r_state == S_SAT) begin
            r_val <= w_val;
        end
        if (r_state == S_PMUL) begin
            r_p <= tdd_pkg::P_W'(r_val) * tdd_pkg::P_SCALE;
        end
        if (r_state == S_DIFF) begin
            r_diff  <= (w_e_ext >= w_p_ext) ? tdd_pkg::DVD_W'(w_e_ext - w_p_ext)
                                            : tdd_pkg::DVD_W'(w_p_ext - w_e_ext);
            r_e_big <= (r_e > tdd_pkg::E_MIN);
        end
        if (r_state == S_CMP && w_out_free) begin
            r_m_chan <= r_func;
            r_m_val  <= r_val;
            r_m_mism <= w_mism;
        end
    end

    tdd_bitdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_full[tdd_pkg::DVD_W-1:0]),
        .i_divisor  (r_den),
        .o_quotient (w_quot),
        .o_stat     (w_div_stat)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_mism, r_m_val};
    assign o_m_tuser  = r_m_chan;

    // Alarm on a held result of any channel but input power
    assign w_flag_other = r_m_valid && r_m_mism && (r_m_chan != tdd_pkg::FUNC_PIN);

    // Checks
    `ASSERT_CLK(a_ready_div_idle, i_clk, i_rst_n, o_s_tready |-> !w_div_stat.busy)
    `ASSERT_CLK(a_xfer_starts_work, i_clk, i_rst_n, w_in_xfer |=> (r_state == S_MUL))
    `ASSERT_CLK(a_done_in_div, i_clk, i_rst_n, w_div_stat.done |-> (r_state == S_DIV))
    `ASSERT_NEVER(a_mism_only_pin, i_clk, i_rst_n, w_flag_other)

endmodule

### tb/sv/tb_telemetry_direct_decode.sv
// Self-checking testbench for the direct-format telemetry decoder.
`timescale 1ns / 1ps

module tb_telemetry_direct_decode;

    localparam int FUNC_W = tdd_pkg::FUNC_W;
    localparam int RAW_W  = tdd_pkg::RAW_W;
    localparam int VAL_W  = tdd_pkg::VAL_W;
    localparam int RES_W  = tdd_pkg::RES_W;
    localparam int VIN_W  = tdd_pkg::VIN_W;
    localparam int IIN_W  = tdd_pkg::IIN_W;

    localparam int TLAST_GAP  = 17;          // longest idle either side draws per transfer
    localparam int DRAIN_WAIT = 80;          // settling margin after the last reading drains
    localparam int PHASE_SIZE = 100;         // least number of random words per resistor setting

    // Selectors 5..7 name no channel; the block echoes them with a zero value
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd5;

    // Decode scale factors and divisors, kept signed 64-bit so products stay signed
    localparam longint SCALE_VOLT = 64'sd100000;
    localparam longint SCALE_CURR = 64'sd100000000000;
    localparam longint SCALE_POW  = 64'sd1000000000000;
    localparam longint DIV_VOLT   = 64'sd5251;
    localparam longint GAIN_CURR  = 64'sd9538;
    localparam longint GAIN_POW   = 64'sd4901;
    localparam longint TEMP_OFS   = 64'sd32100;
    localparam longint POW_FLOOR  = 64'sd100000;   // 0.1 W in microwatts

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic signed [RAW_W-1:0] raw;
    } t_word;

    typedef struct {
        logic [FUNC_W-1:0]       channel;
        logic signed [VAL_W-1:0] value;
        logic                    mismatch;
    } t_reading;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [RES_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_tvalid  = 1'b0;
    logic [15:0]       i_s_tdata   = '0;   // [15:0] raw_word
    logic [2:0]        i_s_tuser   = '0;   // [2:0] func
    logic              i_m_tready  = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [39:0]       o_m_tdata;          // [37:0] value_milli, [38] pwr_alarm
    logic [2:0]        o_m_tuser;          // [2:0] channel

    t_word    words_to_send[$];   // filled by the stimulus, drained by the driver
    t_reading readings_due[$];    // decoded readings still to come out of the block

    // Shadow of the block's register and stored telemetry
    logic [RES_W-1:0] res_shadow  = tdd_pkg::RES_RESET;
    longint           vin_held_mv = 0;
    longint           iin_held_ma = 0;

    int errors     = 0;
    bit calm       = 1'b0;   // set to run a stretch with no idling on either side
    int send_gap   = 0;
    int take_stall = 0;

    telemetry_direct_decode u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Round to nearest, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Pure decode of one raw word in milli-units; a zero resistor counts as one centiohm
    function automatic longint channel_value(logic [FUNC_W-1:0] func,
                                             logic signed [RAW_W-1:0] raw,
                                             logic [RES_W-1:0] res);
        longint y;
        longint c;
        y = raw;
        c = (res == '0) ? 64'sd1 : longint'(res);
        case (func)
            tdd_pkg::FUNC_VIN,
            tdd_pkg::FUNC_VOUT: return div_nearest(y * SCALE_VOLT, DIV_VOLT);
            tdd_pkg::FUNC_IIN:
                return clamp_signed(div_nearest(y * SCALE_CURR, GAIN_CURR * c), VAL_W);
            tdd_pkg::FUNC_PIN:
                return clamp_signed(div_nearest(y * SCALE_POW, GAIN_POW * c), VAL_W);
            tdd_pkg::FUNC_TEMP: return div_nearest((y * 100 - TEMP_OFS) * 50, 7);
            default:   return 0;
        endcase
    endfunction

    // Decode an accepted word, update the held V and I, and run the power cross-check
    function automatic t_reading decode_word(t_word w);
        t_reading r;
        longint   v;
        longint   e;
        longint   p;
        longint   diff;
        v = channel_value(w.func, w.raw, res_shadow);
        r.channel  = w.func;
        r.value    = v[VAL_W-1:0];
        r.mismatch = 1'b0;
        case (w.func)
            tdd_pkg::FUNC_VIN: vin_held_mv = clamp_signed(v, VIN_W);
            tdd_pkg::FUNC_IIN: iin_held_ma = clamp_signed(v, IIN_W);
            tdd_pkg::FUNC_PIN: begin
                e = vin_held_mv * iin_held_ma;
                p = v * 1000;
                if (e > POW_FLOOR) begin
                    diff = (e >= p) ? e - p : p - e;
                    r.mismatch = (diff * 20 > e * 3);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: predict on each input transfer, then present the next word after its gap
    always @(posedge i_clk) begin
        t_word got;
        t_word w;
        bit    holding;
        if (!i_rst_n) begin
            holding = 1'b0;
        end else begin
            holding = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                got.func = i_s_tuser;
                got.raw  = i_s_tdata;
                readings_due.push_back(decode_word(got));
                holding = 1'b0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (words_to_send.size() > 0) begin
                    w = words_to_send.pop_front();
                    i_s_tuser <= w.func;
                    i_s_tdata <= w.raw;
                    holding = 1'b1;
                    send_gap = calm ? 0 : $urandom_range(0, TLAST_GAP);
                end
            end
        end
        // one assignment per edge keeps valid high across back-to-back words
        i_s_tvalid <= holding;
    end

    // Monitor: compare each result transfer with the oldest decoded reading
    always @(posedge i_clk) begin
        t_reading want;
        bit       ready;
        if (!i_rst_n) begin
            ready = 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result with nothing pending: channel %0d value %0d flag %0b",
                             $time, o_m_tuser, $signed(o_m_tdata[VAL_W-1:0]), o_m_tdata[VAL_W]);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    if (o_m_tuser !== want.channel) begin
                        $display("%0t: channel expected %0d, got %0d",
                                 $time, want.channel, o_m_tuser);
                        errors++;
                    end
                    if (o_m_tdata[VAL_W-1:0] !== want.value) begin
                        $display("%0t: value on channel %0d expected %0d, got %0d",
                                 $time, want.channel, want.value,
                                 $signed(o_m_tdata[VAL_W-1:0]));
                        errors++;
                    end
                    if (o_m_tdata[VAL_W] !== want.mismatch) begin
                        $display("%0t: power flag on channel %0d expected %0b, got %0b",
                                 $time, want.channel, want.mismatch, o_m_tdata[VAL_W]);
                        errors++;
                    end
                end
                take_stall = calm ? 0 : $urandom_range(0, TLAST_GAP);
            end
            // hold ready low for the drawn stall, then accept again
            ready = (take_stall == 0);
            if (take_stall > 0) take_stall--;
        end
        i_m_tready <= ready;
    end

    task automatic queue_word(logic [FUNC_W-1:0] func, logic signed [RAW_W-1:0] raw);
        t_word w;
        w.func = func;
        w.raw  = raw;
        words_to_send.push_back(w);
    endtask

    // Block until the driver is empty and every reading has come out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || i_s_tvalid || readings_due.size() != 0);
    endtask

    initial begin
        logic [RES_W-1:0] settings[8];
        longint yv;
        longint yi;
        longint v_mv;
        longint i_ma;
        longint c;
        real    yp_real;
        int     n;

        settings = '{20'd100, 20'd1000000, 20'hFFFFF, 20'd0, 20'd1,
                     20'd100, 20'd0, tdd_pkg::RES_RESET};
        settings[5] = RES_W'($urandom_range(100, 1000000));
        settings[6] = RES_W'($urandom());

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an extreme word on every channel, spare selectors, power cross-check
        queue_word(tdd_pkg::FUNC_VIN,  16'sh7FFF);
        queue_word(tdd_pkg::FUNC_VIN,  -16'sh8000);
        queue_word(tdd_pkg::FUNC_VOUT, 16'sh0000);
        queue_word(tdd_pkg::FUNC_VOUT, 16'sh7FFF);
        queue_word(tdd_pkg::FUNC_IIN,  16'sh7FFF);
        queue_word(tdd_pkg::FUNC_IIN,  -16'sh8000);
        queue_word(tdd_pkg::FUNC_PIN,  -16'sh8000);
        queue_word(tdd_pkg::FUNC_IIN,  16'sh0000);
        queue_word(tdd_pkg::FUNC_TEMP, 16'sh7FFF);
        queue_word(tdd_pkg::FUNC_TEMP, -16'sh8000);
        queue_word(tdd_pkg::FUNC_TEMP, 16'sd321);          // exactly zero degrees
        queue_word(FUNC_SPARE,         16'sh7FFF);
        queue_word(FUNC_SPARE + 3'd1,  -16'sh8000);
        queue_word(FUNC_SPARE + 3'd2,  16'sh5555);
        // about 19 V and 10.5 A: 98 agrees with V*I, 60 and the negative word do not
        queue_word(tdd_pkg::FUNC_VIN,  16'sd1000);
        queue_word(tdd_pkg::FUNC_IIN,  16'sd100);
        queue_word(tdd_pkg::FUNC_VOUT, 16'sd1);            // must not disturb the held voltage
        queue_word(tdd_pkg::FUNC_PIN,  16'sd98);
        queue_word(tdd_pkg::FUNC_PIN,  16'sd60);
        queue_word(tdd_pkg::FUNC_PIN,  -16'sh8000);
        queue_word(tdd_pkg::FUNC_VIN,  16'sd0);            // zero V*I never flags
        queue_word(tdd_pkg::FUNC_PIN,  16'sd98);

        foreach (settings[k]) begin
            // pause the sender so the register changes only while the block is idle
            wait_drained();
            calm = (k == 2 || k == 6);
            @(posedge i_clk);
            i_cfg_wdata <= settings[k];
            i_cfg_we    <= 1'b1;
            res_shadow   = settings[k];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;

            c = (res_shadow == '0) ? 64'sd1 : longint'(res_shadow);
            n = 0;
            while (n < PHASE_SIZE) begin
                if ($urandom_range(0, 9) < 6) begin
                    // well-formed vin, iin, pin run with pin near V*I, some outside 15%
                    yv = $urandom_range(1, 32767);
                    yi = $urandom_range(1, (1 << $urandom_range(1, 15)) - 1);
                    if ($urandom_range(0, 9) == 0) yv = -yv;
                    if ($urandom_range(0, 9) == 0) yi = -yi;
                    v_mv = clamp_signed(channel_value(tdd_pkg::FUNC_VIN, RAW_W'(yv),
                                                      res_shadow), VIN_W);
                    i_ma = clamp_signed(channel_value(tdd_pkg::FUNC_IIN, RAW_W'(yi),
                                                      res_shadow), IIN_W);
                    yp_real = real'(v_mv) * real'(i_ma) * 4901.0 * real'(c) / 1.0e15
                              * real'($urandom_range(70, 130)) / 100.0;
                    if (yp_real > 32767.0) yp_real = 32767.0;
                    if (yp_real < -32768.0) yp_real = -32768.0;
                    queue_word(tdd_pkg::FUNC_VIN, RAW_W'(yv));
                    if ($urandom_range(0, 3) == 0) begin
                        queue_word(tdd_pkg::FUNC_VOUT, RAW_W'($urandom()));
                        n++;
                    end
                    queue_word(tdd_pkg::FUNC_IIN, RAW_W'(yi));
                    if ($urandom_range(0, 3) == 0) begin
                        queue_word(tdd_pkg::FUNC_TEMP, RAW_W'($urandom()));
                        n++;
                    end
                    queue_word(tdd_pkg::FUNC_PIN, RAW_W'(longint'(yp_real)));
                    n += 3;
                end else begin
                    // noise: any selector, any raw word
                    queue_word(FUNC_W'($urandom_range(0, 7)), RAW_W'($urandom()));
                    n++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run; a correct run takes well under a millisecond
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
